### sv/assert_macros.svh
// Assertion macros shared by the deframer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled during reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/ddf_pkg.sv
// Types, constants and the CRC-16/X25 step shared by the deframer modules
`default_nettype none

package ddf_pkg;

  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [7:0]  HdrByte0   = 8'hFF;
  localparam logic [7:0]  HdrByte1   = 8'hBB;
  localparam logic [7:0]  MinLen     = 8'd6;
  localparam logic [7:0]  FirstBody  = 8'd3;
  localparam logic [7:0]  HbByte0    = 8'hEE;
  localparam logic [7:0]  HbByte1    = 8'hAA;
  localparam logic [7:0]  HbLenByte  = 8'h16;
  localparam logic [7:0]  HbTypeByte = 8'h06;
  localparam logic [15:0] CrcInit    = 16'hFFFF;
  localparam logic [15:0] CrcPoly    = 16'h8408;
  localparam logic [31:0] IpReset    = 32'hFFFF_FFFF;
  localparam logic [7:0]  IdGps      = 8'd1;
  localparam logic [7:0]  IdDevice   = 8'd2;
  localparam logic [4:0]  LastResIdx = 5'd22;
  localparam logic [4:0]  HbCrcStart = 5'd20;

  localparam int unsigned PaddrWidth = 3;
  localparam logic        RegLocalIpv4 = 1'b0;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StCrcErr  = 2'd1,
    StLenErr  = 2'd2,
    StTimeout = 2'd3
  } status_t;

  typedef enum logic {
    ReqByte    = 1'b0,
    ReqTimeout = 1'b1
  } req_kind_t;

  typedef enum logic {
    KindStatus = 1'b0,
    KindHb     = 1'b1
  } res_kind_t;

  typedef struct packed {
    logic        hb;
    status_t     status;
    logic [7:0]  frame_id;
    logic [31:0] uptime;
    logic [31:0] gps;
    logic [31:0] dev;
  } job_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### sv/ddf_ifs.sv
// Valid/ready channel interfaces for request and result items
`default_nettype none

interface ddf_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [7:0]  rx_byte;
  logic [31:0] uptime_s;
  modport source (output valid, req_type, rx_byte, uptime_s, input ready);
  modport sink (input valid, req_type, rx_byte, uptime_s, output ready);
endinterface

interface ddf_rsp_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [1:0]  status;
  logic [7:0]  frame_id;
  logic [7:0]  tx_byte;
  logic        last;
  logic [31:0] gps_count;
  logic [31:0] device_count;
  modport source (output valid, kind, status, frame_id, tx_byte, last, gps_count,
                  device_count, input ready);
  modport sink (input valid, kind, status, frame_id, tx_byte, last, gps_count,
                device_count, output ready);
endinterface

`default_nettype wire

### sv/crc16_x25_frame_deframer_top.sv
// Top level of the CRC-16/X25 frame deframer with APB register port
//
// Takes one request item per cycle (received byte or receive timeout) as long as
// the job queue has room; header hunting, length check, CRC and frame counting
// finish in the cycle of acceptance. Each input that yields results queues one
// job; the result sequencer then delivers one result item per cycle through its
// output register while the receiver is ready: one status item, or a status item
// followed by the 22-byte heartbeat for a frame with good CRC. The output stage at
// one item per cycle sets the sustained worst case for frame-ending bytes; up to
// QUEUE_DEPTH jobs wait between parser and sequencer. Register local_ipv4 sits at
// byte address 0 (reset all ones, meaning no address).
`default_nettype none

module crc16_x25_frame_deframer_top import ddf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  ddf_req_if.sink                    req,
  ddf_rsp_if.source                  rsp,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PaddrWidth-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [31:0] local_ipv4;
  logic        push;
  job_t        push_job;
  logic        q_full;
  logic        pop;
  logic        head_valid;
  job_t        head;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegLocalIpv4) ? local_ipv4 : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_ipv4 <= IpReset;
    end else if (psel && penable && pwrite && pready && paddr[2] == RegLocalIpv4) begin
      local_ipv4 <= pwdata;
    end
  end

  ddf_front u_front (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .q_full (q_full),
    .push   (push),
    .job    (push_job)
  );

  ddf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  ddf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (head_valid),
    .job        (head),
    .pop        (pop),
    .local_ipv4 (local_ipv4),
    .rsp        (rsp)
  );

endmodule

`default_nettype wire

### sv/ddf_queue.sv
// Small register FIFO of result jobs between parser and result sequencer
`default_nettype none
`include "assert_macros.svh"

module ddf_queue import ddf_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepthDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  job_t      push_job,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output job_t      head
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  job_t            entries [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full       = (count == CntFull);
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `ASSERT_CLK(a_no_push_full, push |-> !full, "job pushed into full queue")
  `ASSERT_CLK(a_no_pop_empty, pop |-> head_valid, "job popped from empty queue")
  `ASSERT_ALWAYS(a_count_range, rst || (count <= CntFull), "queue count beyond depth")

endmodule

`default_nettype wire

### sv/ddf_front.sv
// Frame parser: hunts headers, checks length and CRC, counts frames, queues jobs
`default_nettype none
`include "assert_macros.svh"

module ddf_front import ddf_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  ddf_req_if.sink     req,
  input  wire logic   q_full,
  output logic        push,
  output job_t        job
);

  typedef enum logic [3:0] {
    PhHuntFf = 4'b0001,
    PhHuntBb = 4'b0010,
    PhLen    = 4'b0100,
    PhBody   = 4'b1000
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  frame_len, frame_len_next;
  logic [7:0]  byte_index, byte_index_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  crc_low_byte, crc_low_byte_next;
  logic [7:0]  held_id, held_id_next;
  logic [31:0] gps_total, gps_total_next;
  logic [31:0] device_total, device_total_next;

  logic        accept;
  logic [7:0]  b;
  logic [7:0]  crc_pos;
  logic [15:0] crc_got;

  assign req.ready = !q_full;
  assign accept    = req.valid && req.ready;
  assign b         = req.rx_byte;
  assign crc_pos   = frame_len - 8'd2;
  assign crc_got   = {b, crc_low_byte};

  always_comb begin
    phase_next        = phase;
    frame_len_next    = frame_len;
    byte_index_next   = byte_index;
    running_crc_next  = running_crc;
    crc_low_byte_next = crc_low_byte;
    held_id_next      = held_id;
    gps_total_next    = gps_total;
    device_total_next = device_total;
    push              = 1'b0;
    job               = '0;
    job.uptime        = req.uptime_s;
    if (accept) begin
      if (req.req_type == ReqTimeout) begin
        if (phase == PhLen || phase == PhBody) begin
          push         = 1'b1;
          job.status   = StTimeout;
          job.frame_id = held_id;
        end
        phase_next = PhHuntFf;
      end else begin
        unique case (phase)
          PhHuntBb: begin
            if (b == HdrByte1) begin
              running_crc_next = crc_byte(running_crc, b);
              phase_next       = PhLen;
            end else begin
              phase_next = PhHuntFf;
            end
          end
          PhLen: begin
            if (b < MinLen) begin
              push       = 1'b1;
              job.status = StLenErr;
              phase_next = PhHuntFf;
            end else begin
              frame_len_next   = b;
              running_crc_next = crc_byte(running_crc, b);
              byte_index_next  = FirstBody;
              phase_next       = PhBody;
            end
          end
          PhBody: begin
            if (byte_index == FirstBody) begin
              held_id_next = b;
            end
            if (byte_index < crc_pos) begin
              running_crc_next = crc_byte(running_crc, b);
            end else if (byte_index == crc_pos) begin
              crc_low_byte_next = b;
            end else begin
              phase_next   = PhHuntFf;
              push         = 1'b1;
              job.frame_id = held_id;
              if (crc_got != ~running_crc) begin
                job.status = StCrcErr;
              end else begin
                job.status = StOk;
                job.hb     = 1'b1;
                if (held_id == IdGps) begin
                  gps_total_next = gps_total + 32'd1;
                end else if (held_id == IdDevice) begin
                  device_total_next = device_total + 32'd1;
                end
              end
            end
            byte_index_next = byte_index + 8'd1;
          end
          default: begin
            if (b == HdrByte0) begin
              running_crc_next  = crc_byte(CrcInit, b);
              held_id_next      = '0;
              crc_low_byte_next = '0;
              byte_index_next   = '0;
              phase_next        = PhHuntBb;
            end else begin
              phase_next = PhHuntFf;
            end
          end
        endcase
      end
    end
    job.gps = gps_total_next;
    job.dev = device_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PhHuntFf;
      frame_len    <= '0;
      byte_index   <= '0;
      running_crc  <= CrcInit;
      crc_low_byte <= '0;
      held_id      <= '0;
      gps_total    <= '0;
      device_total <= '0;
    end else begin
      phase        <= phase_next;
      frame_len    <= frame_len_next;
      byte_index   <= byte_index_next;
      running_crc  <= running_crc_next;
      crc_low_byte <= crc_low_byte_next;
      held_id      <= held_id_next;
      gps_total    <= gps_total_next;
      device_total <= device_total_next;
    end
  end

  `ASSERT_CLK(a_gps_needs_job, !$stable(gps_total) |-> $past(push), "gps count moved without job")
  `ASSERT_CLK(a_dev_needs_job, !$stable(device_total) |-> $past(push), "device count moved without job")
  `ASSERT_CLK(a_hb_only_ok, (push && job.hb) |-> (job.status == StOk), "heartbeat on bad frame")

endmodule

`default_nettype wire

### sv/ddf_back.sv
// Result sequencer: expands each job into a status item and optional heartbeat bytes
`default_nettype none
`include "assert_macros.svh"

module ddf_back import ddf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        job_valid,
  input  job_t             job,
  output logic             pop,
  input  wire logic [31:0] local_ipv4,
  ddf_rsp_if.source        rsp
);

  logic [4:0]  res_idx;
  logic [15:0] hb_crc;
  logic        load;
  logic [4:0]  hb_pos;
  logic [7:0]  hb_byte;
  logic [15:0] hb_crc_out;
  logic        res_last;

  assign load       = job_valid && (!rsp.valid || rsp.ready);
  assign hb_pos     = res_idx - 5'd1;
  assign hb_crc_out = ~hb_crc;
  assign res_last   = (res_idx == '0) ? !job.hb : (res_idx == LastResIdx);
  assign pop        = load && res_last;

  always_comb begin
    unique case (hb_pos[4:2])
      3'd0: begin
        unique case (hb_pos[1:0])
          2'd0: hb_byte = HbByte0;
          2'd1: hb_byte = HbByte1;
          2'd2: hb_byte = HbLenByte;
          default: hb_byte = HbTypeByte;
        endcase
      end
      3'd1:    hb_byte = job.uptime[{hb_pos[1:0], 3'b000} +: 8];
      3'd2:    hb_byte = job.gps[{hb_pos[1:0], 3'b000} +: 8];
      3'd3:    hb_byte = job.dev[{hb_pos[1:0], 3'b000} +: 8];
      3'd4:    hb_byte = local_ipv4[{hb_pos[1:0], 3'b000} +: 8];
      default: hb_byte = hb_pos[0] ? hb_crc_out[15:8] : hb_crc_out[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.gps_count    <= job.gps;
      rsp.device_count <= job.dev;
      rsp.last         <= res_last;
      if (res_idx == '0) begin
        rsp.kind     <= KindStatus;
        rsp.status   <= job.status;
        rsp.frame_id <= job.frame_id;
        rsp.tx_byte  <= '0;
        hb_crc       <= CrcInit;
      end else begin
        rsp.kind     <= KindHb;
        rsp.status   <= StOk;
        rsp.frame_id <= '0;
        rsp.tx_byte  <= hb_byte;
        if (hb_pos < HbCrcStart) begin
          hb_crc <= crc_byte(hb_crc, hb_byte);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
      res_idx   <= '0;
    end else begin
      if (load) begin
        rsp.valid <= 1'b1;
        res_idx   <= res_last ? '0 : res_idx + 5'd1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  `ASSERT_ALWAYS(a_idx_range, rst || (res_idx <= LastResIdx), "result index past heartbeat end")
  `ASSERT_CLK(a_idx_needs_hb, (res_idx != '0) |-> (job_valid && job.hb), "heartbeat index without job")

endmodule

`default_nettype wire

### verif/crc16_x25_frame_deframer_top_test.sv
// Self-checking testbench for the CRC-16/X25 frame deframer top level
`timescale 1ns / 1ps

module crc16_x25_frame_deframer_top_test import ddf_pkg::*; ();

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned LongHold = 300;
  localparam int unsigned IdleSettle = 8;
  localparam int unsigned DrainCycles = 30;
  localparam logic [PaddrWidth-1:0] IpAddr = PaddrWidth'(4 * RegLocalIpv4);
  localparam logic [PaddrWidth-1:0] SpareAddr = PaddrWidth'(4 * (RegLocalIpv4 + 1));

  typedef enum logic [1:0] {
    SeekFf,
    SeekBb,
    GetLen,
    GetBody
  } seek_t;

  typedef struct packed {
    res_kind_t   kind;
    status_t     status;
    logic [7:0]  frame_id;
    logic [7:0]  tx_byte;
    logic        last;
    logic [31:0] gps;
    logic [31:0] dev;
  } deframe_res_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PaddrWidth-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  ddf_req_if req_ch ();
  ddf_rsp_if rsp_ch ();

  crc16_x25_frame_deframer_top u_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  seek_t       seek;
  logic [7:0]  frame_len;
  logic [7:0]  frame_idx;
  logic [15:0] crc_acc;
  logic [7:0]  crc_lo;
  logic [7:0]  held_id;
  logic [31:0] gps_total;
  logic [31:0] dev_total;
  logic [31:0] ip_addr;

  deframe_res_t due_results[$];
  deframe_res_t seen_res;
  deframe_res_t due_res;
  int unsigned  mismatches = 0;
  int unsigned  live_items = 0;
  int unsigned  cycles = 0;

  int unsigned  burst_left = 0;
  bit           steady_tx = 1'b0;
  int unsigned  hold_reqs = 0;
  int unsigned  hold_seen = 0;
  int unsigned  hold_left = 0;
  int unsigned  rx_cyc = 0;
  logic [6:0]   stall_pat = 7'b1011001;
  logic         rx_rdy;

  always #2 clk = ~clk;

  function automatic logic [15:0] x25_next(input logic [15:0] c, input logic [7:0] b);
    logic [7:0] d;
    d = b ^ c[7:0];
    d = d ^ (d << 4);
    return {d, c[15:8]} ^ {12'h000, d[7:4]} ^ ({8'h00, d} << 3);
  endfunction

  function automatic deframe_res_t make_res(input res_kind_t k, input status_t s,
                                            input logic [7:0] id, input logic [7:0] tx);
    deframe_res_t r;
    r.kind = k;
    r.status = s;
    r.frame_id = id;
    r.tx_byte = tx;
    r.last = 1'b0;
    r.gps = gps_total;
    r.dev = dev_total;
    return r;
  endfunction

  function automatic void predict_deframe(input req_kind_t rt, input logic [7:0] b,
                                          input logic [31:0] up);
    deframe_res_t res[23];
    logic [7:0]   hb[22];
    logic [15:0]  hc;
    int           n;
    int           i;
    n = 0;
    if (!(seek == SeekFf && (rt == ReqTimeout || b != HdrByte0))) begin
      live_items++;
    end
    if (rt == ReqTimeout) begin
      if (seek == GetLen || seek == GetBody) begin
        res[n] = make_res(KindStatus, StTimeout, held_id, 8'h00);
        n = n + 1;
      end
      seek = SeekFf;
    end else begin
      case (seek)
        SeekBb: begin
          if (b == HdrByte1) begin
            crc_acc = x25_next(crc_acc, b);
            seek = GetLen;
          end else begin
            seek = SeekFf;
          end
        end
        GetLen: begin
          if (b < MinLen) begin
            res[n] = make_res(KindStatus, StLenErr, 8'h00, 8'h00);
            n = n + 1;
            seek = SeekFf;
          end else begin
            frame_len = b;
            crc_acc = x25_next(crc_acc, b);
            frame_idx = FirstBody;
            seek = GetBody;
          end
        end
        GetBody: begin
          if (frame_idx == FirstBody) held_id = b;
          if (frame_idx < frame_len - 8'd2) begin
            crc_acc = x25_next(crc_acc, b);
          end else if (frame_idx == frame_len - 8'd2) begin
            crc_lo = b;
          end else begin
            seek = SeekFf;
            if ({b, crc_lo} != ~crc_acc) begin
              res[n] = make_res(KindStatus, StCrcErr, held_id, 8'h00);
              n = n + 1;
            end else begin
              if (held_id == IdGps) gps_total = gps_total + 1;
              else if (held_id == IdDevice) dev_total = dev_total + 1;
              res[n] = make_res(KindStatus, StOk, held_id, 8'h00);
              n = n + 1;
              hb[0] = HbByte0;
              hb[1] = HbByte1;
              hb[2] = HbLenByte;
              hb[3] = HbTypeByte;
              for (i = 0; i < 4; i++) begin
                hb[4 + i] = up[8*i +: 8];
                hb[8 + i] = gps_total[8*i +: 8];
                hb[12 + i] = dev_total[8*i +: 8];
                hb[16 + i] = ip_addr[8*i +: 8];
              end
              hc = CrcInit;
              for (i = 0; i < 20; i++) hc = x25_next(hc, hb[i]);
              hc = ~hc;
              hb[20] = hc[7:0];
              hb[21] = hc[15:8];
              for (i = 0; i < 22; i++) begin
                res[n] = make_res(KindHb, StOk, 8'h00, hb[i]);
                n = n + 1;
              end
            end
          end
          frame_idx = frame_idx + 8'd1;
        end
        default: begin
          if (b == HdrByte0) begin
            crc_acc = x25_next(CrcInit, b);
            held_id = 8'h00;
            crc_lo = 8'h00;
            frame_idx = 8'h00;
            seek = SeekBb;
          end else begin
            seek = SeekFf;
          end
        end
      endcase
    end
    if (n > 0) res[n-1].last = 1'b1;
    for (i = 0; i < n; i++) due_results = {due_results, res[i]};
  endfunction

  function automatic logic [31:0] pick_uptime();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 32'h0000_0000;
    if (p == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic logic [7:0] pick_id();
    int p;
    p = $urandom_range(0, 9);
    if (p < 4) return IdGps;
    if (p < 7) return IdDevice;
    return 8'($urandom);
  endfunction

  task automatic send_req(input req_kind_t rt, input logic [7:0] b, input logic [31:0] up);
    int gap;
    @(negedge clk);
    if (!steady_tx && burst_left == 0) begin
      gap = $urandom_range(1, 10);
      burst_left = $urandom_range(1, 24);
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= rt;
    req_ch.rx_byte <= b;
    req_ch.uptime_s <= up;
    do @(posedge clk); while (!req_ch.ready);
    if (burst_left > 0) burst_left--;
    predict_deframe(rt, b, up);
  endtask

  task automatic send_frame(input int len, input logic [7:0] id, input bit spoil, input int cut,
                            input bit abort, input logic [31:0] up_last);
    logic [15:0] crc;
    logic [15:0] fcs;
    logic [7:0]  b;
    int          i;
    crc = CrcInit;
    fcs = 16'h0000;
    for (i = 0; i < cut; i++) begin
      if (i == 0) b = HdrByte0;
      else if (i == 1) b = HdrByte1;
      else if (i == 2) b = 8'(len);
      else if (i == 3) b = id;
      else if (i < len - 2) b = 8'($urandom);
      else if (i == len - 2) begin
        fcs = ~crc;
        if (spoil) fcs = fcs ^ (16'h0001 << $urandom_range(0, 15));
        b = fcs[7:0];
      end else b = fcs[15:8];
      if (i < len - 2) crc = x25_next(crc, b);
      send_req(ReqByte, b, (i == len - 1) ? up_last : pick_uptime());
    end
    if (abort) send_req(ReqTimeout, 8'($urandom), pick_uptime());
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    burst_left = 0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (IdleSettle) @(posedge clk);
  endtask

  task automatic apb_write(input logic [PaddrWidth-1:0] addr, input logic [31:0] data);
    logic [31:0] rd_exp;
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == IpAddr) ip_addr = data;
    @(negedge clk);
    rd_exp = (addr == IpAddr) ? data : 32'h0000_0000;
    if (prdata !== rd_exp) begin
      mismatches++;
      $display("%0t: register read mismatch, expected %h, got %h", $time, rd_exp, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic test_header_hunting();
    send_req(ReqByte, 8'h00, 32'h0000_0000);
    send_req(ReqTimeout, 8'hFF, 32'hFFFF_FFFF);
    send_req(ReqByte, HdrByte0, pick_uptime());
    send_req(ReqTimeout, 8'h00, pick_uptime());
    send_req(ReqByte, HdrByte0, pick_uptime());
    send_req(ReqByte, 8'hFF, pick_uptime());
  endtask

  task automatic test_length_check();
    send_req(ReqByte, HdrByte0, pick_uptime());
    send_req(ReqByte, HdrByte1, pick_uptime());
    send_req(ReqByte, MinLen - 8'd1, pick_uptime());
  endtask

  task automatic test_timeout_abort();
    send_frame(7, IdDevice, 1'b0, 4, 1'b1, pick_uptime());
  endtask

  task automatic test_crc_check();
    send_frame(6, IdGps, 1'b0, 6, 1'b0, 32'hFFFF_FFFF);
    send_frame(6, IdDevice, 1'b1, 6, 1'b0, 32'h0000_0000);
  endtask

  task automatic test_output_backpressure();
    int k;
    wait_idle();
    steady_tx = 1'b1;
    hold_reqs++;
    for (k = 0; k < 6; k++) send_frame(6 + k, pick_id(), 1'b0, 6 + k, 1'b0, pick_uptime());
    steady_tx = 1'b0;
    wait_idle();
  endtask

  task automatic test_spare_register();
    wait_idle();
    apb_write(SpareAddr, $urandom);
  endtask

  task automatic test_random_traffic(input int n_items, input logic [31:0] ip,
                                     input bit max_len);
    int unsigned target;
    int          pick;
    int          len;
    logic [7:0]  b;
    wait_idle();
    apb_write(IpAddr, ip);
    if (max_len) send_frame(255, IdDevice, 1'b0, 255, 1'b0, pick_uptime());
    target = live_items + n_items;
    while (live_items < target) begin
      steady_tx = ($urandom_range(0, 9) == 0);
      pick = $urandom_range(0, 99);
      len = ($urandom_range(0, 99) < 85) ? $urandom_range(6, 16) : $urandom_range(17, 48);
      if (pick < 55) begin
        send_frame(len, pick_id(), 1'b0, len, 1'b0, pick_uptime());
      end else if (pick < 65) begin
        send_frame(len, pick_id(), 1'b1, len, 1'b0, pick_uptime());
      end else if (pick < 75) begin
        send_frame(len, pick_id(), 1'b0, $urandom_range(1, len - 1), 1'b1, pick_uptime());
      end else if (pick < 78) begin
        send_frame(len, pick_id(), 1'b0, $urandom_range(1, len - 1), 1'b0, pick_uptime());
      end else if (pick < 85) begin
        send_req(ReqByte, HdrByte0, pick_uptime());
        send_req(ReqByte, HdrByte1, pick_uptime());
        send_req(ReqByte, 8'($urandom_range(0, 5)), pick_uptime());
      end else if (pick < 93) begin
        send_req(ReqByte, 8'($urandom), pick_uptime());
      end else if (pick < 97) begin
        b = 8'($urandom);
        if (b == HdrByte1) b = 8'h00;
        send_req(ReqByte, HdrByte0, pick_uptime());
        send_req(ReqByte, b, pick_uptime());
      end else begin
        send_req(ReqTimeout, 8'($urandom), pick_uptime());
      end
    end
    steady_tx = 1'b0;
  endtask

  // receiver: own stall pattern plus long hold-offs on request
  always @(negedge clk) begin
    rx_cyc = rx_cyc + 1;
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = LongHold;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rx_rdy = 1'b0;
    end else begin
      case (rx_cyc[9:8])
        2'd0: rx_rdy = 1'b1;
        2'd1: rx_rdy = ($urandom_range(0, 3) != 0);
        2'd2: rx_rdy = stall_pat[rx_cyc % 7];
        default: rx_rdy = ($urandom_range(0, 2) == 0);
      endcase
    end
    rsp_ch.ready <= rx_rdy;
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      seen_res = {rsp_ch.kind, rsp_ch.status, rsp_ch.frame_id, rsp_ch.tx_byte, rsp_ch.last,
                  rsp_ch.gps_count, rsp_ch.device_count};
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches < 40) begin
          $display("%0t: unexpected result, expected none, got kind %0d status %0d id %h",
                   $time, seen_res.kind, seen_res.status, seen_res.frame_id,
                   " tx %h last %0d gps %0d dev %0d", seen_res.tx_byte, seen_res.last,
                   seen_res.gps, seen_res.dev);
        end
      end else begin
        due_res = due_results.pop_front();
        if (seen_res !== due_res) begin
          mismatches++;
          if (mismatches < 40) begin
            $display("%0t: result mismatch, expected kind %0d status %0d id %h tx %h",
                     $time, due_res.kind, due_res.status, due_res.frame_id, due_res.tx_byte,
                     " last %0d gps %0d dev %0d", due_res.last, due_res.gps, due_res.dev);
            $display("%0t: result mismatch, got      kind %0d status %0d id %h tx %h",
                     $time, seen_res.kind, seen_res.status, seen_res.frame_id,
                     seen_res.tx_byte, " last %0d gps %0d dev %0d", seen_res.last,
                     seen_res.gps, seen_res.dev);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles > CycleLimit) begin
      $display("crc16_x25_frame_deframer_top_test: done, errors");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = 32'h0000_0000;
    req_ch.valid = 1'b0;
    req_ch.req_type = ReqByte;
    req_ch.rx_byte = 8'h00;
    req_ch.uptime_s = 32'h0000_0000;
    rsp_ch.ready = 1'b0;
    seek = SeekFf;
    frame_len = 8'h00;
    frame_idx = 8'h00;
    crc_acc = CrcInit;
    crc_lo = 8'h00;
    held_id = 8'h00;
    gps_total = 32'h0000_0000;
    dev_total = 32'h0000_0000;
    ip_addr = IpReset;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_header_hunting();
    test_length_check();
    test_timeout_abort();
    test_crc_check();
    test_output_backpressure();
    test_random_traffic(40, 32'h0000_0000, 1'b1);
    test_spare_register();
    test_random_traffic(40, $urandom, 1'b0);
    test_random_traffic(40, 32'hFFFF_FFFF, 1'b0);
    test_random_traffic(40, $urandom, 1'b0);

    wait_idle();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("crc16_x25_frame_deframer_top_test: done, clean");
    end else begin
      $display("crc16_x25_frame_deframer_top_test: done, errors");
    end
    $finish;
  end

endmodule
